### rtl/hcrp_pkg.sv
// Shared types and constants for the configuration record parser.
// Result item layout, parse phases, field ids and header byte positions.
// No dependencies; imported by every module of the block.
package hcrp_pkg;

  // Results one input byte can cause at most
  localparam int unsigned RES_SLOTS = 4;
  localparam int unsigned VAL_W     = 44;

  // Configuration register indexes
  localparam logic REG_LAYERED   = 1'b0;
  localparam logic REG_AVAILABLE = 1'b1;

  // Parse phase of the record
  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ARRAY    = 3'd1,
    PH_COUNT_HI = 3'd2,
    PH_COUNT_LO = 3'd3,
    PH_SIZE_HI  = 3'd4,
    PH_SIZE_LO  = 3'd5,
    PH_PAYLOAD  = 3'd6,
    PH_DONE     = 3'd7
  } hcrp_phase_t;

  // One result item, field_id in the low bits
  typedef struct packed {
    logic              last;
    logic [15:0]       unit_index;
    logic [7:0]        array_index;
    logic [VAL_W-1:0]  field_value;
    logic [4:0]        field_id;
  } hcrp_result_t;

  typedef hcrp_result_t [RES_SLOTS-1:0] hcrp_result_vec_t;

  // Field ids
  localparam logic [4:0] FID_VERSION     = 5'd0;
  localparam logic [4:0] FID_PROF_SPACE  = 5'd1;
  localparam logic [4:0] FID_TIER        = 5'd2;
  localparam logic [4:0] FID_PROF_IDC    = 5'd3;
  localparam logic [4:0] FID_COMPAT      = 5'd4;
  localparam logic [4:0] FID_PROGRESSIVE = 5'd5;
  localparam logic [4:0] FID_INTERLACED  = 5'd6;
  localparam logic [4:0] FID_NON_PACKED  = 5'd7;
  localparam logic [4:0] FID_FRAME_ONLY  = 5'd8;
  localparam logic [4:0] FID_CONSTRAINT  = 5'd9;
  localparam logic [4:0] FID_LEVEL       = 5'd10;
  localparam logic [4:0] FID_MIN_SEG     = 5'd11;
  localparam logic [4:0] FID_PARALLEL    = 5'd12;
  localparam logic [4:0] FID_CHROMA_FMT  = 5'd13;
  localparam logic [4:0] FID_LUMA_DEPTH  = 5'd14;
  localparam logic [4:0] FID_CHROMA_DEP  = 5'd15;
  localparam logic [4:0] FID_AVG_RATE    = 5'd16;
  localparam logic [4:0] FID_CONST_RATE  = 5'd17;
  localparam logic [4:0] FID_TEMP_LAYERS = 5'd18;
  localparam logic [4:0] FID_TEMP_NESTED = 5'd19;
  localparam logic [4:0] FID_LEN_SIZE    = 5'd20;
  localparam logic [4:0] FID_ARRAY_COUNT = 5'd21;
  localparam logic [4:0] FID_COMPLETE    = 5'd22;
  localparam logic [4:0] FID_NAL_TYPE    = 5'd23;
  localparam logic [4:0] FID_UNIT_COUNT  = 5'd24;
  localparam logic [4:0] FID_UNIT_SIZE   = 5'd25;
  localparam logic [4:0] FID_PAYLOAD     = 5'd26;
  localparam logic [4:0] FID_REC_DONE    = 5'd27;
  localparam logic [4:0] FID_ERROR       = 5'd28;

  // Error codes carried in field_value of an error result
  localparam logic [VAL_W-1:0] ERR_SIZE  = 44'd0;
  localparam logic [VAL_W-1:0] ERR_TRUNC = 44'd1;

  // Header byte positions; all but SEG_LO and RATE_HI complete a field
  localparam logic [4:0] HP_VERSION   = 5'd0;
  localparam logic [4:0] HP_PROFILE   = 5'd1;
  localparam logic [4:0] HP_COMPAT    = 5'd5;
  localparam logic [4:0] HP_FLAGS     = 5'd6;
  localparam logic [4:0] HP_CONSTR    = 5'd11;
  localparam logic [4:0] HP_LEVEL     = 5'd12;
  localparam logic [4:0] HP_SEG_LO    = 5'd13;
  localparam logic [4:0] HP_MIN_SEG   = 5'd14;
  localparam logic [4:0] HP_PARALLEL  = 5'd15;
  localparam logic [4:0] HP_CHROMA    = 5'd16;
  localparam logic [4:0] HP_LUMA      = 5'd17;
  localparam logic [4:0] HP_CHR_DEPTH = 5'd18;
  localparam logic [4:0] HP_RATE_HI   = 5'd19;
  localparam logic [4:0] HP_AVG_RATE  = 5'd20;
  localparam logic [4:0] HP_TEMPORAL  = 5'd21;
  localparam logic [4:0] HP_ARRAYS    = 5'd22;

  localparam logic [23:0] BC_MAX = 24'hFF_FFFF;

  function automatic hcrp_result_t make_result(input logic [4:0] id,
                                               input logic [VAL_W-1:0] val,
                                               input logic [7:0] ai,
                                               input logic [15:0] ui);
    hcrp_result_t r;
    r.last        = 1'b0;
    r.unit_index  = ui;
    r.array_index = ai;
    r.field_value = val;
    r.field_id    = id;
    return r;
  endfunction

endpackage

### rtl/hcrp_parser.sv
// Parse state of the configuration record and the result set of one byte.
// Depends on hcrp_pkg for phases, field ids and the result type.
// State advances once per taken byte; results go out as a set of up to four.
module hcrp_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  logic [7:0]                byte_value,
  input  logic                      end_of_input,
  input  logic                      layered_mode,
  input  logic [23:0]               available_bytes,
  output hcrp_pkg::hcrp_result_vec_t res,
  output logic [2:0]                res_count
);
  import hcrp_pkg::*;

  logic [4:0]   hpos, hpos_next;
  logic [47:0]  acc, acc_next;
  logic [7:0]   arrays_total, arrays_total_next;
  logic [7:0]   array_counter, array_counter_next;
  logic [15:0]  units_total, units_total_next;
  logic [15:0]  unit_counter, unit_counter_next;
  logic [15:0]  payload_rem, payload_rem_next;
  logic [23:0]  bytes_consumed, bytes_consumed_next;
  hcrp_phase_t  phase, phase_next;

  logic         arr_last, unit_last, size_over;
  logic [23:0]  bc_inc;
  logic [24:0]  rem_diff;
  logic [23:0]  rem;
  logic [15:0]  size_word, count_word;
  logic [15:0]  payload_dec;
  logic [7:0]   b;
  logic [2:0]   n;
  hcrp_result_vec_t r;

  assign b           = byte_value;
  assign arr_last    = ({1'b0, array_counter} + 9'd1) >= {1'b0, arrays_total};
  assign unit_last   = ({1'b0, unit_counter} + 17'd1) >= {1'b0, units_total};
  assign size_word   = {acc[7:0], b};
  assign count_word  = {acc[7:0], b};
  assign payload_dec = payload_rem - 16'd1;

  // Byte count including this byte, saturating, frozen once done
  assign bc_inc = (phase != PH_DONE && bytes_consumed != BC_MAX) ?
                  bytes_consumed + 24'd1 : bytes_consumed;

  // Bytes left from the available budget, floored at zero
  assign rem_diff  = {1'b0, available_bytes} - {1'b0, bc_inc};
  assign rem       = rem_diff[24] ? 24'd0 : rem_diff[23:0];
  assign size_over = {8'd0, size_word} > rem;

  // Next state and the results of this byte
  always_comb begin
    hpos_next           = hpos;
    acc_next            = acc;
    arrays_total_next   = arrays_total;
    array_counter_next  = array_counter;
    units_total_next    = units_total;
    unit_counter_next   = unit_counter;
    payload_rem_next    = payload_rem;
    phase_next          = phase;
    bytes_consumed_next = bc_inc;
    n = 3'd0;
    r = '0;

    unique case (phase)
      PH_HEADER: begin
        acc_next  = {acc[39:0], b};
        hpos_next = hpos + 5'd1;
        case (hpos)
          HP_VERSION: begin
            r[n[1:0]] = make_result(FID_VERSION, {36'd0, b}, array_counter, unit_counter);
            n = n + 3'd1;
            hpos_next = layered_mode ? HP_SEG_LO : HP_PROFILE;
          end
          HP_PROFILE: begin
            r[n[1:0]] = make_result(FID_PROF_SPACE, {42'd0, b[7:6]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
            r[n[1:0]] = make_result(FID_TIER, {43'd0, b[5]}, array_counter, unit_counter);
            n = n + 3'd1;
            r[n[1:0]] = make_result(FID_PROF_IDC, {39'd0, b[4:0]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
          end
          HP_COMPAT: begin
            r[n[1:0]] = make_result(FID_COMPAT, {12'd0, acc_next[31:0]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
          end
          HP_FLAGS: begin
            r[n[1:0]] = make_result(FID_PROGRESSIVE, {43'd0, b[7]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
            r[n[1:0]] = make_result(FID_INTERLACED, {43'd0, b[6]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
            r[n[1:0]] = make_result(FID_NON_PACKED, {43'd0, b[5]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
            r[n[1:0]] = make_result(FID_FRAME_ONLY, {43'd0, b[4]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
          end
          HP_CONSTR: begin
            r[n[1:0]] = make_result(FID_CONSTRAINT, acc_next[43:0], array_counter,
                                    unit_counter);
            n = n + 3'd1;
          end
          HP_LEVEL: begin
            r[n[1:0]] = make_result(FID_LEVEL, {36'd0, b}, array_counter, unit_counter);
            n = n + 3'd1;
          end
          HP_MIN_SEG: begin
            r[n[1:0]] = make_result(FID_MIN_SEG, {32'd0, acc_next[11:0]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
          end
          HP_PARALLEL: begin
            r[n[1:0]] = make_result(FID_PARALLEL, {42'd0, b[1:0]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
            hpos_next = layered_mode ? HP_TEMPORAL : HP_CHROMA;
          end
          HP_CHROMA: begin
            r[n[1:0]] = make_result(FID_CHROMA_FMT, {42'd0, b[1:0]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
          end
          HP_LUMA: begin
            r[n[1:0]] = make_result(FID_LUMA_DEPTH, {40'd0, {1'b0, b[2:0]} + 4'd8},
                                    array_counter, unit_counter);
            n = n + 3'd1;
          end
          HP_CHR_DEPTH: begin
            r[n[1:0]] = make_result(FID_CHROMA_DEP, {40'd0, {1'b0, b[2:0]} + 4'd8},
                                    array_counter, unit_counter);
            n = n + 3'd1;
          end
          HP_AVG_RATE: begin
            r[n[1:0]] = make_result(FID_AVG_RATE, {28'd0, acc_next[15:0]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
          end
          HP_TEMPORAL: begin
            if (!layered_mode) begin
              r[n[1:0]] = make_result(FID_CONST_RATE, {42'd0, b[7:6]}, array_counter,
                                      unit_counter);
              n = n + 3'd1;
            end
            r[n[1:0]] = make_result(FID_TEMP_LAYERS, {41'd0, b[5:3]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
            r[n[1:0]] = make_result(FID_TEMP_NESTED, {43'd0, b[2]}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
            r[n[1:0]] = make_result(FID_LEN_SIZE, {41'd0, {1'b0, b[1:0]} + 3'd1},
                                    array_counter, unit_counter);
            n = n + 3'd1;
          end
          HP_ARRAYS: begin
            r[n[1:0]] = make_result(FID_ARRAY_COUNT, {36'd0, b}, array_counter,
                                    unit_counter);
            n = n + 3'd1;
            arrays_total_next  = b;
            array_counter_next = 8'd0;
            unit_counter_next  = 16'd0;
            hpos_next          = HP_VERSION;
            if (b == 8'd0) begin
              phase_next = PH_DONE;
              r[n[1:0]] = make_result(FID_REC_DONE, 44'd1, 8'd0, 16'd0);
              n = n + 3'd1;
            end else begin
              phase_next = PH_ARRAY;
            end
          end
          default: begin
            hpos_next = hpos + 5'd1;
          end
        endcase
      end

      PH_ARRAY: begin
        r[n[1:0]] = make_result(FID_COMPLETE, {43'd0, b[7]}, array_counter, unit_counter);
        n = n + 3'd1;
        r[n[1:0]] = make_result(FID_NAL_TYPE, {38'd0, b[5:0]}, array_counter, unit_counter);
        n = n + 3'd1;
        phase_next = PH_COUNT_HI;
      end

      PH_COUNT_HI: begin
        acc_next   = {40'd0, b};
        phase_next = PH_COUNT_LO;
      end

      PH_COUNT_LO: begin
        units_total_next  = count_word;
        unit_counter_next = 16'd0;
        r[n[1:0]] = make_result(FID_UNIT_COUNT, {28'd0, count_word}, array_counter,
                                unit_counter);
        n = n + 3'd1;
        if (count_word == 16'd0) begin
          // empty array: move on to the next one, or finish the record after the last
          if (arr_last) begin
            phase_next = PH_DONE;
            r[n[1:0]] = make_result(FID_REC_DONE, 44'd1, 8'd0, 16'd0);
            n = n + 3'd1;
          end else begin
            array_counter_next = array_counter + 8'd1;
            phase_next         = PH_ARRAY;
          end
        end else begin
          phase_next = PH_SIZE_HI;
        end
      end

      PH_SIZE_HI: begin
        acc_next   = {40'd0, b};
        phase_next = PH_SIZE_LO;
      end

      PH_SIZE_LO: begin
        r[n[1:0]] = make_result(FID_UNIT_SIZE, {28'd0, size_word}, array_counter,
                                unit_counter);
        n = n + 3'd1;
        if (size_over) begin
          r[n[1:0]] = make_result(FID_ERROR, ERR_SIZE, array_counter, unit_counter);
          n = n + 3'd1;
          phase_next = PH_DONE;
        end else if (size_word == 16'd0) begin
          // empty unit
          if (!unit_last) begin
            unit_counter_next = unit_counter + 16'd1;
            phase_next        = PH_SIZE_HI;
          end else if (arr_last) begin
            phase_next = PH_DONE;
            r[n[1:0]] = make_result(FID_REC_DONE, 44'd1, 8'd0, 16'd0);
            n = n + 3'd1;
          end else begin
            array_counter_next = array_counter + 8'd1;
            unit_counter_next  = 16'd0;
            phase_next         = PH_ARRAY;
          end
        end else begin
          payload_rem_next = size_word;
          phase_next       = PH_PAYLOAD;
        end
      end

      PH_PAYLOAD: begin
        r[n[1:0]] = make_result(FID_PAYLOAD, {36'd0, b}, array_counter, unit_counter);
        n = n + 3'd1;
        payload_rem_next = payload_dec;
        if (payload_dec == 16'd0) begin
          if (!unit_last) begin
            unit_counter_next = unit_counter + 16'd1;
            phase_next        = PH_SIZE_HI;
          end else if (arr_last) begin
            phase_next = PH_DONE;
            r[n[1:0]] = make_result(FID_REC_DONE, 44'd1, 8'd0, 16'd0);
            n = n + 3'd1;
          end else begin
            array_counter_next = array_counter + 8'd1;
            unit_counter_next  = 16'd0;
            phase_next         = PH_ARRAY;
          end
        end
      end

      PH_DONE: begin
      end
    endcase

    // End of input: flag a truncated record, then back to the start
    if (end_of_input) begin
      if (phase_next != PH_DONE) begin
        if (n == 3'd4) begin
          n = 3'd3;
        end
        r[n[1:0]] = make_result(FID_ERROR, ERR_TRUNC, array_counter_next,
                                unit_counter_next);
        n = n + 3'd1;
      end
      hpos_next           = 5'd0;
      acc_next            = '0;
      arrays_total_next   = 8'd0;
      array_counter_next  = 8'd0;
      units_total_next    = 16'd0;
      unit_counter_next   = 16'd0;
      payload_rem_next    = 16'd0;
      bytes_consumed_next = 24'd0;
      phase_next          = PH_HEADER;
    end

    // Mark the final result of this byte
    if (n != 3'd0) begin
      r[n[1:0] - 2'd1].last = 1'b1;
    end
  end

  assign res       = r;
  assign res_count = n;

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hpos           <= 5'd0;
      acc            <= '0;
      arrays_total   <= 8'd0;
      array_counter  <= 8'd0;
      units_total    <= 16'd0;
      unit_counter   <= 16'd0;
      payload_rem    <= 16'd0;
      bytes_consumed <= 24'd0;
      phase          <= PH_HEADER;
    end else if (take) begin
      hpos           <= hpos_next;
      acc            <= acc_next;
      arrays_total   <= arrays_total_next;
      array_counter  <= array_counter_next;
      units_total    <= units_total_next;
      unit_counter   <= unit_counter_next;
      payload_rem    <= payload_rem_next;
      bytes_consumed <= bytes_consumed_next;
      phase          <= phase_next;
    end
  end

`ifndef SYNTH
  // Payload phase is only entered with bytes left to read
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_rem != 16'd0)
    else $error("payload phase with no bytes left");

  // Inside the arrays the array counter stays below the array count
  a_array_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HEADER && phase != PH_DONE) |-> array_counter < arrays_total)
    else $error("array counter past array count");

  // A taken end-of-input byte always leaves the parser at the record start
  a_eoi_restart: assert property (@(posedge clk) disable iff (rst)
    take && end_of_input |=> phase == PH_HEADER && hpos == 5'd0 && bytes_consumed == 24'd0)
    else $error("parser not back at start after end of input");
`endif

endmodule

### rtl/hcrp_result_queue.sv
// Holds the result set of one byte and drains it one item per cycle unless stalled.
// Depends on hcrp_pkg for the result type; drives the output stream register.
// A new set loads while the last entry of the previous one moves out.
module hcrp_result_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  hcrp_pkg::hcrp_result_vec_t ld_res,
  input  logic [2:0]                 ld_count,
  output logic                       can_load,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [79:0]                m_tdata,   // field_id[4:0], field_value[48:5],
                                                // array_index[56:49], unit_index[72:57]
  output logic                       m_tlast    // last_of_run
);
  import hcrp_pkg::*;

  hcrp_result_t entries [RES_SLOTS];
  hcrp_result_t head;
  logic [1:0]   rd_ptr;
  logic [2:0]   cnt;
  logic         pop;

  assign pop      = (cnt != 3'd0) && (!m_tvalid || m_tready);
  assign can_load = (cnt == 3'd0) || (cnt == 3'd1 && pop);
  assign head     = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < RES_SLOTS; i++) begin
        entries[i] <= ld_res[i];
      end
    end
  end

  // Fill count and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 3'd0;
      rd_ptr <= 2'd0;
    end else if (load) begin
      cnt    <= ld_count;
      rd_ptr <= 2'd0;
    end else if (pop) begin
      cnt    <= cnt - 3'd1;
      rd_ptr <= rd_ptr + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {7'd0, head.unit_index, head.array_index, head.field_value, head.field_id};
      m_tlast <= head.last;
    end
  end

`ifndef SYNTH
  // Fill count never exceeds the slot count
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd4)
    else $error("result queue count out of range");

  // The final entry of a set goes out marked as last of run
  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    pop && cnt == 3'd1 |=> m_tvalid && m_tlast)
    else $error("final result of a byte not marked last");
`endif

endmodule

### rtl/hevc_config_record_parser_core.sv
// Configuration record parser: one byte in, up to four tagged field results out per byte.
// Uses an input register stage, hcrp_parser and hcrp_result_queue.
// Depends on hcrp_pkg for the result type and register indexes.
//
// Bytes enter on the s_ stream, one per accepted item; tlast marks the last byte
// available, after which the parser returns to the record start. Each byte produces
// 0 to 4 result items on the m_ stream, and the last result of a byte carries tlast.
// The single output port drains each byte's result set one item per cycle unless m_tready
// stalls it; the next byte loads as the last result moves out, so bytes with one result
// or none stream at one per cycle while unstalled. A byte passes the input register, its
// results the queue entries and the output register. Registers: index 0 is layered_mode
// (bit 0), index 1 is available_bytes; write them only while no byte is in flight.
module hevc_config_record_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // byte_value[7:0]
  input  logic        s_tlast,    // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,    // field_id[4:0], field_value[48:5],
                                  // array_index[56:49], unit_index[72:57]
  output logic        m_tlast,    // last_of_run
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);
  import hcrp_pkg::*;

  logic             layered_mode;
  logic [23:0]      available_bytes;
  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_eoi;
  logic             take;
  logic             can_load;
  hcrp_result_vec_t res;
  logic [2:0]       res_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      layered_mode    <= 1'b0;
      available_bytes <= 24'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAYERED:   layered_mode    <= cfg_data[0];
        REG_AVAILABLE: available_bytes <= cfg_data;
      endcase
    end
  end

  // Input register
  assign take     = in_valid && can_load;
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eoi  <= s_tlast;
    end
  end

  hcrp_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .byte_value      (in_byte),
    .end_of_input    (in_eoi),
    .layered_mode    (layered_mode),
    .available_bytes (available_bytes),
    .res             (res),
    .res_count       (res_count)
  );

  hcrp_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .ld_res   (res),
    .ld_count (res_count),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### tb/hevc_config_record_parser_core_tb.sv
// Self-checking testbench for hevc_config_record_parser_core.
// Drives record bytes on the s_ stream and checks every field result on the m_ stream
// against a cycle-free parser model kept here; uses types and codes from hcrp_pkg.
`timescale 1ns / 100ps

module hevc_config_record_parser_core_tb;
  import hcrp_pkg::*;

  localparam int   DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_data;

  // Parser model state
  logic              cfg_layered;
  logic [23:0]       cfg_avail;
  logic [4:0]        hdr_pos;
  logic [47:0]       acc48;
  logic [7:0]        arr_total;
  logic [7:0]        arr_idx;
  logic [15:0]       unit_total;
  logic [15:0]       unit_idx;
  logic [15:0]       pay_left;
  logic [23:0]       byte_count;
  hcrp_phase_t       phase;

  hcrp_result_t byte_fields[$];
  hcrp_result_t pending_fields[$];
  logic [7:0]   rec_bytes[$];

  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  bit          src_idle;
  bit          sink_idle;
  int          out_hold;

  hevc_config_record_parser_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function automatic void clear_state();
    hdr_pos    = HP_VERSION;
    acc48      = '0;
    arr_total  = '0;
    arr_idx    = '0;
    unit_total = '0;
    unit_idx   = '0;
    pay_left   = '0;
    byte_count = '0;
    phase      = PH_HEADER;
  endfunction

  // At most four results per byte; extras are dropped
  function automatic void put_field(input logic [4:0] id, input logic [VAL_W-1:0] v,
                                    input logic [7:0] ai, input logic [15:0] ui);
    hcrp_result_t r;
    if (byte_fields.size() >= RES_SLOTS) return;
    r.last        = 1'b0;
    r.unit_index  = ui;
    r.array_index = ai;
    r.field_value = v;
    r.field_id    = id;
    byte_fields.push_back(r);
  endfunction

  function automatic void put_here(input logic [4:0] id, input logic [VAL_W-1:0] v);
    put_field(id, v, arr_idx, unit_idx);
  endfunction

  function automatic void finish_array();
    if ({1'b0, arr_idx} + 9'd1 >= {1'b0, arr_total}) begin
      phase = PH_DONE;
      put_field(FID_REC_DONE, 44'd1, 8'd0, 16'd0);
    end else begin
      arr_idx  = arr_idx + 8'd1;
      unit_idx = '0;
      phase    = PH_ARRAY;
    end
  endfunction

  function automatic void finish_unit();
    if ({1'b0, unit_idx} + 17'd1 >= {1'b0, unit_total}) begin
      finish_array();
    end else begin
      unit_idx = unit_idx + 16'd1;
      phase    = PH_SIZE_HI;
    end
  endfunction

  function automatic void header_byte(input logic [7:0] b);
    logic [4:0] nxt;
    nxt   = hdr_pos + 5'd1;
    acc48 = {acc48[39:0], b};
    case (hdr_pos)
      HP_VERSION: begin
        put_here(FID_VERSION, 44'(b));
        if (cfg_layered) nxt = HP_SEG_LO;
      end
      HP_PROFILE: begin
        put_here(FID_PROF_SPACE, 44'(b[7:6]));
        put_here(FID_TIER, 44'(b[5]));
        put_here(FID_PROF_IDC, 44'(b[4:0]));
      end
      HP_COMPAT: put_here(FID_COMPAT, 44'(acc48[31:0]));
      HP_FLAGS: begin
        put_here(FID_PROGRESSIVE, 44'(b[7]));
        put_here(FID_INTERLACED, 44'(b[6]));
        put_here(FID_NON_PACKED, 44'(b[5]));
        put_here(FID_FRAME_ONLY, 44'(b[4]));
      end
      HP_CONSTR:    put_here(FID_CONSTRAINT, acc48[43:0]);
      HP_LEVEL:     put_here(FID_LEVEL, 44'(b));
      HP_MIN_SEG:   put_here(FID_MIN_SEG, 44'(acc48[11:0]));
      HP_PARALLEL: begin
        put_here(FID_PARALLEL, 44'(b[1:0]));
        nxt = cfg_layered ? HP_TEMPORAL : HP_CHROMA;
      end
      HP_CHROMA:    put_here(FID_CHROMA_FMT, 44'(b[1:0]));
      HP_LUMA:      put_here(FID_LUMA_DEPTH, 44'(b[2:0]) + 44'd8);
      HP_CHR_DEPTH: put_here(FID_CHROMA_DEP, 44'(b[2:0]) + 44'd8);
      HP_AVG_RATE:  put_here(FID_AVG_RATE, 44'(acc48[15:0]));
      HP_TEMPORAL: begin
        if (!cfg_layered) put_here(FID_CONST_RATE, 44'(b[7:6]));
        put_here(FID_TEMP_LAYERS, 44'(b[5:3]));
        put_here(FID_TEMP_NESTED, 44'(b[2]));
        put_here(FID_LEN_SIZE, 44'(b[1:0]) + 44'd1);
      end
      HP_ARRAYS: begin
        put_here(FID_ARRAY_COUNT, 44'(b));
        arr_total = b;
        arr_idx   = '0;
        unit_idx  = '0;
        if (b == 8'd0) begin
          phase = PH_DONE;
          put_field(FID_REC_DONE, 44'd1, 8'd0, 16'd0);
        end else begin
          phase = PH_ARRAY;
        end
        nxt = HP_VERSION;
      end
      default: ;
    endcase
    hdr_pos = nxt;
  endfunction

  // Works out the results of one accepted byte and queues them
  function automatic void parse_byte(input logic [7:0] b, input logic eoi);
    logic [15:0] usize;
    logic [23:0] room;
    byte_fields.delete();
    if (phase != PH_DONE && byte_count < BC_MAX) byte_count = byte_count + 24'd1;
    case (phase)
      PH_HEADER: header_byte(b);
      PH_ARRAY: begin
        put_here(FID_COMPLETE, 44'(b[7]));
        put_here(FID_NAL_TYPE, 44'(b[5:0]));
        phase = PH_COUNT_HI;
      end
      PH_COUNT_HI: begin
        acc48 = 48'(b);
        phase = PH_COUNT_LO;
      end
      PH_COUNT_LO: begin
        unit_total = {acc48[7:0], b};
        unit_idx   = '0;
        put_here(FID_UNIT_COUNT, 44'(unit_total));
        if (unit_total == 16'd0) finish_array();
        else phase = PH_SIZE_HI;
      end
      PH_SIZE_HI: begin
        acc48 = 48'(b);
        phase = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        usize = {acc48[7:0], b};
        put_here(FID_UNIT_SIZE, 44'(usize));
        room = (cfg_avail > byte_count) ? cfg_avail - byte_count : 24'd0;
        if (24'(usize) > room) begin
          put_here(FID_ERROR, ERR_SIZE);
          phase = PH_DONE;
        end else if (usize == 16'd0) begin
          finish_unit();
        end else begin
          pay_left = usize;
          phase    = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        put_here(FID_PAYLOAD, 44'(b));
        pay_left = pay_left - 16'd1;
        if (pay_left == 16'd0) finish_unit();
      end
      default: ;
    endcase
    // End of input: truncation error unless finished or dropped, then restart
    if (eoi) begin
      if (phase != PH_DONE) begin
        if (byte_fields.size() == RES_SLOTS) byte_fields.delete(RES_SLOTS - 1);
        put_here(FID_ERROR, ERR_TRUNC);
      end
      clear_state();
    end
    if (byte_fields.size() > 0) byte_fields[byte_fields.size() - 1].last = 1'b1;
    foreach (byte_fields[k]) pending_fields.push_back(byte_fields[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result check
  // ---------------------------------------------------------------------------
  function automatic void check_result(input logic [79:0] d, input logic l);
    hcrp_result_t want;
    if (pending_fields.size() == 0) begin
      $error("unexpected result item: field_id %0d value %0h", d[4:0], d[48:5]);
      mismatches++;
      return;
    end
    want = pending_fields.pop_front();
    if (d[4:0] !== want.field_id) begin
      $error("field_id: expected %0d, got %0d", want.field_id, d[4:0]);
      mismatches++;
    end
    if (d[48:5] !== want.field_value) begin
      $error("field_value: expected %0h, got %0h", want.field_value, d[48:5]);
      mismatches++;
    end
    if (d[56:49] !== want.array_index) begin
      $error("array_index: expected %0d, got %0d", want.array_index, d[56:49]);
      mismatches++;
    end
    if (d[72:57] !== want.unit_index) begin
      $error("unit_index: expected %0d, got %0d", want.unit_index, d[72:57]);
      mismatches++;
    end
    if (d[79:73] !== 7'd0) begin
      $error("tdata pad: expected 0, got %0h", d[79:73]);
      mismatches++;
    end
    if (l !== want.last) begin
      $error("last_of_run: expected %0b, got %0b", want.last, l);
      mismatches++;
    end
  endfunction

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int gap;
    int hold;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (out_hold != 0) begin
        hold     = out_hold;
        out_hold = 0;
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      gap = sink_idle ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      check_result(m_tdata, m_tlast);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (all entered at a falling edge)
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_LAYERED) cfg_layered = val[0];
    else cfg_avail = val;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    int gap;
    gap = src_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_byte(b, eoi);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends rec_bytes with end of input on the last one; optional drain pause
  task automatic send_record(input int pause_at);
    for (int i = 0; i < rec_bytes.size(); i++) begin
      if (i == pause_at) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_fields.size() != 0) @(negedge clk);
      end
      send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
    end
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_fields.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void add_header(input bit layered, input logic [7:0] n_arrays);
    int n;
    n = layered ? 5 : 22;
    repeat (n) rec_bytes.push_back(8'($urandom_range(0, 255)));
    rec_bytes.push_back(n_arrays);
  endfunction

  // One array; big sizes leave the payload short (overflow or truncation)
  function automatic void add_array(input int n_units, input bit big);
    logic [15:0] usize;
    rec_bytes.push_back(8'($urandom_range(0, 255)));
    rec_bytes.push_back(8'd0);
    rec_bytes.push_back(8'(n_units));
    for (int u = 0; u < n_units; u++) begin
      usize = big ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 4));
      rec_bytes.push_back(usize[15:8]);
      rec_bytes.push_back(usize[7:0]);
      for (int p = 0; p < usize && p < 6; p++) rec_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Base layout cut at the flags byte: four results, the fourth becomes the error
  task automatic test_truncated_flags();
    write_reg(REG_LAYERED, 24'd0);
    write_reg(REG_AVAILABLE, 24'hFF_FFFF);
    src_idle  = 0;
    sink_idle = 1;
    rec_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hF0};
    send_record(-1);
    wait_drained();
  endtask

  // Layered layout, no bytes available: empty array, empty unit, then size overflow
  task automatic test_layered_overflow();
    write_reg(REG_LAYERED, 24'd1);
    write_reg(REG_AVAILABLE, 24'd0);
    src_idle  = 1;
    sink_idle = 0;
    rec_bytes = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h02,
                  8'hFF, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'hFF, 8'hFF,
                  8'h5A};
    send_record(-1);
    wait_drained();
  endtask

  // Receiver holds off while bytes keep coming; sender later pauses for a full drain
  task automatic test_output_backpressure();
    write_reg(REG_LAYERED, 24'd1);
    write_reg(REG_AVAILABLE, 24'hFF_FFFF);
    src_idle  = 0;
    sink_idle = 0;
    rec_bytes.delete();
    add_header(1'b1, 8'd1);
    rec_bytes.push_back(8'h21);
    rec_bytes.push_back(8'h00);
    rec_bytes.push_back(8'h01);
    rec_bytes.push_back(8'h00);
    rec_bytes.push_back(8'd24);
    repeat (24) rec_bytes.push_back(8'($urandom_range(0, 255)));
    out_hold = 150;
    send_record(22);
    wait_drained();
  endtask

  // Mostly well-formed records with random content, some cut, padded or noise
  task automatic test_random_records(input int unsigned n_bytes);
    int unsigned stop_at;
    int kind;
    int n_arr;
    int keep;
    int pick;
    stop_at = bytes_sent + n_bytes;
    for (int r = 0; bytes_sent < stop_at; r++) begin
      if (r == 0 || $urandom_range(0, 2) == 0) begin
        wait_drained();
        write_reg(REG_LAYERED, 24'($urandom_range(0, 1)));
        pick = $urandom_range(0, 3);
        case (pick)
          0:       write_reg(REG_AVAILABLE, 24'hFF_FFFF);
          1:       write_reg(REG_AVAILABLE, 24'($urandom_range(0, 60)));
          2:       write_reg(REG_AVAILABLE, 24'd0);
          default: write_reg(REG_AVAILABLE, 24'($urandom_range(0, 24'hFF_FFFF)));
        endcase
      end
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      kind = $urandom_range(0, 9);
      rec_bytes.delete();
      if (kind == 0) begin
        repeat ($urandom_range(1, 12)) rec_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        n_arr = $urandom_range(0, 3);
        add_header(cfg_layered, 8'(n_arr));
        for (int a = 0; a < n_arr; a++) add_array($urandom_range(0, 2), kind == 1);
        if (kind == 2) begin
          keep = $urandom_range(1, rec_bytes.size());
          while (rec_bytes.size() > keep) rec_bytes.delete(rec_bytes.size() - 1);
        end else if (kind == 3) begin
          repeat ($urandom_range(1, 3)) rec_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      send_record(-1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_LAYERED;
    cfg_data    = '0;
    src_idle    = 0;
    sink_idle   = 0;
    out_hold    = 0;
    cfg_layered = 1'b0;
    cfg_avail   = '0;
    clear_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_truncated_flags();
    test_layered_overflow();
    test_output_backpressure();
    test_random_records(100);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_fields.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hcrp_pkg.sv
rtl/hcrp_parser.sv
rtl/hcrp_result_queue.sv
rtl/hevc_config_record_parser_core.sv
tb/hevc_config_record_parser_core_tb.sv
